>>> rtl/serial_image_loader_handshake_defines.svh
// Assertion macros shared by the serial image loader RTL.
`ifndef SERIAL_IMAGE_LOADER_HANDSHAKE_DEFINES_SVH
`define SERIAL_IMAGE_LOADER_HANDSHAKE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SIL_ASSERT_IMPLY(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("implication check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SIL_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/sil_pkg.sv
// Types and constants of the serial image loader.
package sil_pkg;

   // Default capacity of the image buffer in bytes.
   localparam int unsigned SIL_BUFFER_BYTES = 131072;

   // Protocol bytes.
   localparam logic [7:0] SYNC_BYTE  = 8'h5A;
   localparam logic [7:0] TAIL_BYTE0 = 8'h55;
   localparam logic [7:0] TAIL_BYTE1 = 8'hAA;
   localparam logic [7:0] TAIL_BYTE2 = 8'h78;

   // Status codes that open a response frame.
   localparam logic [7:0] CODE_OK    = 8'h00;
   localparam logic [7:0] CODE_SYNC  = 8'h01;
   localparam logic [7:0] CODE_DATA  = 8'h02;
   localparam logic [7:0] CODE_FLASH = 8'h03;

   // Loader phase.
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_LOAD   = 2'd2,
      PH_BUSY   = 2'd3
   } phase_type;

   // Kind of one result transaction.
   typedef enum logic [1:0] {
      KIND_RESP  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READY = 2'd2
   } out_kind_type;

   // Kind of a pending result group.
   typedef enum logic {
      DESC_FRAME = 1'b0,
      DESC_WRITE = 1'b1
   } desc_kind_type;

   // One group of results caused by one input transaction.
   typedef struct packed {
      desc_kind_type kind;
      logic          two_frames;
      logic [7:0]    code_a;
      logic [7:0]    code_b;
      logic [16:0]   addr;
      logic [7:0]    data;
      logic          with_ready;
   } desc_type;

   // Hand-off of a result group from the protocol core to the output stage.
   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

endpackage

>>> rtl/sil_if.sv
// Valid/ready channel interfaces for requests and results.
interface sil_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;
   logic       check_ok;
   logic       flash_ok;

   modport source (output valid, output cmd, output rx_byte, output check_ok,
                   output flash_ok, input ready);
   modport sink   (input valid, input cmd, input rx_byte, input check_ok,
                   input flash_ok, output ready);
endinterface

interface sil_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [16:0] write_addr;
   logic [7:0]  out_data;
   logic        last;

   modport source (output valid, output out_kind, output write_addr, output out_data,
                   output last, input ready);
   modport sink   (input valid, input out_kind, input write_addr, input out_data,
                   input last, output ready);
endinterface

>>> rtl/sil_core.sv
// Input register, protocol state machine and result group generation.
module sil_core import sil_pkg::*; #(
   parameter int unsigned BUFFER_BYTES = SIL_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   sil_req_if.sink     req_bus,
   input  logic        desc_ready,
   output push_type    desc_push
);

   localparam logic [31:0] SizeLimit = 32'(BUFFER_BYTES);

   logic        in_valid_ff;
   logic        in_cmd_ff;
   logic [7:0]  in_byte_ff;
   logic        in_check_ff;
   logic        in_flash_ff;
   logic [31:0] expected_magic_ff;
   phase_type   phase_ff, phase_in;
   logic [17:0] byte_count_ff, byte_count_in;
   logic [31:0] magic_ff, magic_in;
   logic [31:0] size_ff, size_in;

   logic        has_results;
   logic        advance;
   logic [17:0] count_inc;
   logic [31:0] size_full;
   logic        header_bad;
   logic        load_done;
   desc_type    desc;

   // Shared decode terms.
   assign count_inc  = byte_count_ff + 18'd1;
   assign size_full  = {in_byte_ff, size_ff[31:8]};
   assign header_bad = (magic_ff != expected_magic_ff) || (size_full == 32'd0) ||
                       (size_full > SizeLimit);
   assign load_done  = (32'(count_inc) == size_ff);

   // The held transaction moves on when its results, if any, have room.
   assign advance       = in_valid_ff && (!has_results || desc_ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_magic_ff <= '0;
      end else if (csr_wr_en) begin
         expected_magic_ff <= csr_wr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_cmd_ff   <= req_bus.cmd;
         in_byte_ff  <= req_bus.rx_byte;
         in_check_ff <= req_bus.check_ok;
         in_flash_ff <= req_bus.flash_ok;
      end
   end

   // Next protocol state.
   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      magic_in      = magic_ff;
      size_in       = size_ff;
      if (in_cmd_ff) begin
         if (phase_ff == PH_BUSY) begin
            phase_in = PH_IDLE;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (in_byte_ff == SYNC_BYTE) begin
                  byte_count_in = '0;
                  magic_in      = '0;
                  size_in       = '0;
                  phase_in      = PH_HEADER;
               end
            end
            PH_HEADER: begin
               // Header bytes arrive low byte first, so each one shifts in at the top.
               byte_count_in = count_inc;
               if (!byte_count_ff[2]) begin
                  magic_in = {in_byte_ff, magic_ff[31:8]};
               end else begin
                  size_in = size_full;
               end
               if (byte_count_ff[2:0] == 3'd7) begin
                  if (header_bad) begin
                     phase_in = PH_IDLE;
                  end else begin
                     byte_count_in = '0;
                     phase_in      = PH_LOAD;
                  end
               end
            end
            PH_LOAD: begin
               byte_count_in = count_inc;
               if (load_done) begin
                  phase_in = PH_BUSY;
               end
            end
            PH_BUSY: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Result group for the held transaction.
   always_comb begin
      has_results     = 1'b0;
      desc.kind       = DESC_FRAME;
      desc.two_frames = 1'b0;
      desc.code_a     = CODE_OK;
      desc.code_b     = CODE_OK;
      desc.addr       = byte_count_ff[16:0];
      desc.data       = in_byte_ff;
      desc.with_ready = load_done;
      if (in_cmd_ff) begin
         if (phase_ff == PH_BUSY) begin
            has_results     = 1'b1;
            desc.two_frames = in_check_ff;
            desc.code_a     = in_check_ff ? CODE_OK : CODE_DATA;
            desc.code_b     = in_flash_ff ? CODE_OK : CODE_FLASH;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               has_results = (in_byte_ff == SYNC_BYTE);
            end
            PH_HEADER: begin
               has_results = (byte_count_ff[2:0] == 3'd7);
               desc.code_a = header_bad ? CODE_SYNC : CODE_OK;
            end
            PH_LOAD: begin
               has_results = 1'b1;
               desc.kind   = DESC_WRITE;
            end
            PH_BUSY: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign desc_push.valid = advance && has_results;
   assign desc_push.desc  = desc;

   // Protocol state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_count_ff <= '0;
         magic_ff      <= '0;
         size_ff       <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         magic_ff      <= magic_in;
         size_ff       <= size_in;
      end
   end

endmodule

>>> rtl/sil_result_out.sv
// Result register that expands one result group into its transactions.
module sil_result_out import sil_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type desc_push,
   output logic     desc_ready,
   sil_rsp_if.source rsp_bus
);

   logic       desc_valid_ff;
   desc_type   desc_ff;
   logic [2:0] index_ff;
   logic [2:0] last_index;
   logic       fire;
   logic       is_last;

   // A frame group has four or eight bytes; a write has one or two results.
   always_comb begin
      unique case (desc_ff.kind)
         DESC_FRAME: last_index = desc_ff.two_frames ? 3'd7 : 3'd3;
         DESC_WRITE: last_index = desc_ff.with_ready ? 3'd1 : 3'd0;
         default:    last_index = 3'd0;
      endcase
   end

   assign fire       = desc_valid_ff && rsp_bus.ready;
   assign is_last    = (index_ff == last_index);
   assign desc_ready = !desc_valid_ff || (fire && is_last);

   // Group register and position within the group.
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         index_ff      <= '0;
      end else if (desc_push.valid) begin
         desc_valid_ff <= 1'b1;
         index_ff      <= '0;
      end else if (fire && is_last) begin
         desc_valid_ff <= 1'b0;
      end else if (fire) begin
         index_ff <= index_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_push.valid) begin
         desc_ff <= desc_push.desc;
      end
   end

   // Result fields for the current position.
   always_comb begin
      rsp_bus.valid      = desc_valid_ff;
      rsp_bus.last       = is_last;
      rsp_bus.out_kind   = KIND_RESP;
      rsp_bus.write_addr = '0;
      rsp_bus.out_data   = '0;
      unique case (desc_ff.kind)
         DESC_FRAME: begin
            unique case (index_ff[1:0])
               2'd0:    rsp_bus.out_data = index_ff[2] ? desc_ff.code_b : desc_ff.code_a;
               2'd1:    rsp_bus.out_data = TAIL_BYTE0;
               2'd2:    rsp_bus.out_data = TAIL_BYTE1;
               default: rsp_bus.out_data = TAIL_BYTE2;
            endcase
         end
         DESC_WRITE: begin
            if (index_ff == 3'd0) begin
               rsp_bus.out_kind   = KIND_WRITE;
               rsp_bus.write_addr = desc_ff.addr;
               rsp_bus.out_data   = desc_ff.data;
            end else begin
               rsp_bus.out_kind = KIND_READY;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/serial_image_loader_handshake.sv
// Serial image loader: a request is registered, decoded in one pass and its
// results are produced from a result register behind the input register.
// A request with zero or one result is accepted every cycle while results
// are taken as offered; a payload byte with the final image-ready result or
// a frame sets the rate: one result per ready cycle from the result register.
// Synchronous reset returns to idle with the expected magic cleared to zero.
`include "serial_image_loader_handshake_defines.svh"

module serial_image_loader_handshake import sil_pkg::*; #(
   parameter int unsigned BUFFER_BYTES = SIL_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   sil_req_if.sink     req_bus,
   sil_rsp_if.source   rsp_bus
);

   push_type desc_push;
   logic     desc_ready;

   // Protocol core.
   sil_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .desc_ready  (desc_ready),
      .desc_push   (desc_push)
   );

   // Result serializer.
   sil_result_out u_result_out (
      .clock      (clock),
      .reset      (reset),
      .desc_push  (desc_push),
      .desc_ready (desc_ready),
      .rsp_bus    (rsp_bus)
   );

   // A group is only handed over when the result register has room.
   `SIL_ASSERT_IMPLY(a_push_has_room, desc_push.valid, desc_ready)
   // Image ready always closes the results of its transaction.
   `SIL_ASSERT_IMPLY(a_ready_is_last, rsp_bus.valid && rsp_bus.out_kind == KIND_READY, rsp_bus.last)
   // A buffer write that is not last is followed by image ready.
   `SIL_ASSERT_NEXT(a_write_then_ready, rsp_bus.valid && rsp_bus.ready && rsp_bus.out_kind == KIND_WRITE && !rsp_bus.last, rsp_bus.valid && rsp_bus.out_kind == KIND_READY)

endmodule
